/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every edge outside reset
`define SSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSS_ASSERT(lbl, clk, rst, prop, msg)

`define SSS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/core/sss_pkg.sv */
`default_nettype none

package sss_pkg;

   localparam int MAX_STOPS_DEF = 8;

   localparam int ANGLE_W = 8;
   localparam int DIST_W  = 16;
   localparam int CSR_IDX_W = 2;

   // the sweep never uses a step below this
   localparam int MIN_STEP = 30;

   // x/7 for 8-bit x as (x * 293) >> 11
   localparam int RECIP_W     = 9;
   localparam int RECIP_MUL   = 293;
   localparam int RECIP_SHIFT = 11;

   localparam logic [ANGLE_W-1:0] LOW_ANGLE_RST  = ANGLE_W'(0);
   localparam logic [ANGLE_W-1:0] HIGH_ANGLE_RST = ANGLE_W'(180);

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_MANUAL  = 2'd1,
      OP_REBUILD = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_SERVO  = 2'd0,
      KIND_PING   = 2'd1,
      KIND_REPORT = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_ANGLE   = 2'd0,
      CSR_HIGH_ANGLE  = 2'd1,
      CSR_SCAN_ENABLE = 2'd2
   } csr_idx_type;

   typedef struct packed {
      op_type              op;
      logic                servo_busy;
      logic                echo_ready;
      logic [DIST_W-1:0]   echo_distance;
      logic [ANGLE_W-1:0]  manual_angle;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [ANGLE_W-1:0]  angle;
      logic [DIST_W-1:0]   distance;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/sss_table_build.sv */
`default_nettype none

module sss_table_build #(
   parameter int MAX_STOPS = sss_pkg::MAX_STOPS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic [sss_pkg::ANGLE_W-1:0]            low_angle,
   input  wire logic [sss_pkg::ANGLE_W-1:0]            high_angle,
   input  wire logic [$clog2(MAX_STOPS)-1:0]           rd_index,
   output logic      [sss_pkg::ANGLE_W-1:0]            rd_angle,
   output logic      [$clog2(MAX_STOPS+1)-1:0]         stop_count,
   output logic                                        busy
);
   import sss_pkg::*;

   localparam int N_W   = $clog2(MAX_STOPS);
   localparam int CNT_W = $clog2(MAX_STOPS + 1);
   localparam int A_W   = ANGLE_W + 1;
   localparam int P_W   = ANGLE_W + RECIP_W;

   typedef enum logic [2:0] {
      BLD_IDLE = 3'b001,
      BLD_CALC = 3'b010,
      BLD_WALK = 3'b100
   } bld_state_type;

   bld_state_type state_ff, state_in;
   logic [ANGLE_W-1:0] lo_ff, lo_in;
   logic [ANGLE_W-1:0] hi_ff, hi_in;
   logic [ANGLE_W-1:0] step_ff, step_in;
   logic [A_W-1:0]     pt_ff, pt_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ANGLE_W-1:0] stops_ff [MAX_STOPS];

   logic [ANGLE_W-1:0]         diff;
   logic [P_W-1:0]             prod;
   logic [P_W-RECIP_SHIFT-1:0] quot;
   logic                       walk_go;

   assign diff = hi_ff - lo_ff;
   assign prod = {{RECIP_W{1'b0}}, diff} * {{ANGLE_W{1'b0}}, RECIP_W'(RECIP_MUL)};
   assign quot = prod[P_W-1:RECIP_SHIFT];

   // next point still below the top end and room left before the top end slot
   assign walk_go = (pt_ff < {1'b0, hi_ff}) && (n_ff < N_W'(MAX_STOPS - 1));

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      step_in  = step_ff;
      pt_in    = pt_ff;
      n_in     = n_ff;
      count_in = count_ff;
      case (state_ff)
         BLD_IDLE: begin
            if (start) begin
               if (high_angle < low_angle) begin
                  lo_in = high_angle;
                  hi_in = low_angle;
               end else begin
                  lo_in = low_angle;
                  hi_in = high_angle;
               end
               state_in = BLD_CALC;
            end
         end
         BLD_CALC: begin
            if ({{(ANGLE_W-(P_W-RECIP_SHIFT)){1'b0}}, quot} < ANGLE_W'(MIN_STEP)) begin
               step_in = ANGLE_W'(MIN_STEP);
            end else begin
               step_in = {{(ANGLE_W-(P_W-RECIP_SHIFT)){1'b0}}, quot};
            end
            pt_in    = {1'b0, lo_ff};
            n_in     = '0;
            state_in = BLD_WALK;
         end
         BLD_WALK: begin
            if (walk_go) begin
               pt_in = pt_ff + {1'b0, step_ff};
               n_in  = n_ff + N_W'(1);
            end else begin
               // top end closes the table; a single point doubles up
               if (n_ff == '0) begin
                  count_in = CNT_W'(2);
               end else begin
                  count_in = CNT_W'(n_ff) + CNT_W'(1);
               end
               state_in = BLD_IDLE;
            end
         end
         default: begin
            state_in = BLD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BLD_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      step_ff <= step_in;
      pt_ff   <= pt_in;
      n_ff    <= n_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STOPS; i++) begin
            stops_ff[i] <= '0;
         end
      end else if (state_ff == BLD_WALK) begin
         if (walk_go) begin
            stops_ff[n_ff] <= pt_ff[ANGLE_W-1:0];
         end else begin
            stops_ff[n_ff] <= hi_ff;
            if (n_ff == '0) begin
               stops_ff[1] <= hi_ff;
            end
         end
      end
   end

   assign rd_angle   = stops_ff[rd_index];
   assign stop_count = count_ff;
   assign busy       = (state_ff != BLD_IDLE);

endmodule

`default_nettype wire

/* rtl/core/servo_sonar_scan_sequencer.sv */
`default_nettype none

// channel | direction | handshake           | beat
// req     | in        | req_valid/req_stall | req_data: op, servo_busy, echo, manual angle
// rsp     | out       | rsp_valid/rsp_stall | rsp_data: kind, angle, distance
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// a result of a tick or manual beat sits in the output register
// and the next beat is taken as soon as that register is free or drains.
// a rebuild holds req_stall while the table builder runs: the ends are ordered
// as the beat is taken, then the step multiply, then one table entry per walk step.
// reset is synchronous: table zeroed, registers to defaults, phase to move.
// csr_ready is low while a rebuild runs.

`include "assert_macros.svh"

module servo_sonar_scan_sequencer #(
   parameter int MAX_STOPS = sss_pkg::MAX_STOPS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire sss_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output sss_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sss_pkg::ANGLE_W-1:0]     csr_data
);
   import sss_pkg::*;

   localparam int N_W   = $clog2(MAX_STOPS);
   localparam int CNT_W = $clog2(MAX_STOPS + 1);
   localparam int IDX_W = CNT_W + 1;

   localparam logic signed [IDX_W-1:0] IDX_ZERO = IDX_W'(0);
   localparam logic signed [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
   localparam logic signed [IDX_W-1:0] IDX_TWO  = IDX_W'(2);
   localparam logic signed [IDX_W-1:0] IDX_MAX  = IDX_W'(MAX_STOPS);

   typedef enum logic [2:0] {
      PH_MOVE  = 3'b001,
      PH_SERVO = 3'b010,
      PH_ECHO  = 3'b100
   } phase_type;

   logic [ANGLE_W-1:0]      low_ff, low_in;
   logic [ANGLE_W-1:0]      high_ff, high_in;
   logic                    scan_en_ff, scan_en_in;
   phase_type               phase_ff, phase_in;
   logic signed [IDX_W-1:0] idx_ff, idx_in;
   logic                    down_ff, down_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    req_fire;
   logic                    csr_fire;
   logic                    rsp_load;
   logic                    build_start;
   logic                    build_busy;
   logic [ANGLE_W-1:0]      rd_angle;
   logic [CNT_W-1:0]        stop_count;
   logic [ANGLE_W-1:0]      cur_angle;
   logic signed [IDX_W-1:0] cnt_s;
   logic signed [IDX_W-1:0] adv_idx;
   logic                    adv_down;

   sss_table_build #(
      .MAX_STOPS (MAX_STOPS)
   ) u_build (
      .clock      (clock),
      .reset      (reset),
      .start      (build_start),
      .low_angle  (low_ff),
      .high_angle (high_ff),
      .rd_index   (idx_ff[N_W-1:0]),
      .rd_angle   (rd_angle),
      .stop_count (stop_count),
      .busy       (build_busy)
   );

   assign req_stall = build_busy || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = !build_busy;
   assign csr_fire  = csr_valid && csr_ready;

   // entries outside the storage read as zero
   assign cur_angle = (idx_ff < IDX_ZERO || idx_ff >= IDX_MAX) ? '0 : rd_angle;
   assign cnt_s     = signed'({1'b0, stop_count});

   // ping-pong advance of the table index
   always_comb begin
      adv_idx  = down_ff ? (idx_ff - IDX_ONE) : (idx_ff + IDX_ONE);
      adv_down = down_ff;
      if (adv_idx >= cnt_s) begin
         adv_idx  = cnt_s - IDX_TWO;
         adv_down = 1'b1;
      end
      if (adv_idx < IDX_ZERO) begin
         adv_idx  = IDX_ONE;
         adv_down = 1'b0;
      end
      if (adv_idx == IDX_ZERO) begin
         adv_down = 1'b0;
      end
   end

   always_comb begin
      low_in     = low_ff;
      high_in    = high_ff;
      scan_en_in = scan_en_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_LOW_ANGLE:   low_in     = csr_data;
            CSR_HIGH_ANGLE:  high_in    = csr_data;
            CSR_SCAN_ENABLE: scan_en_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      idx_in          = idx_ff;
      down_in         = down_ff;
      build_start     = 1'b0;
      rsp_load        = 1'b0;
      rsp_in.kind     = KIND_SERVO;
      rsp_in.angle    = cur_angle;
      rsp_in.distance = '0;
      if (req_fire) begin
         case (req_data.op)
            OP_REBUILD: begin
               build_start = 1'b1;
            end
            OP_MANUAL: begin
               if (!scan_en_ff) begin
                  rsp_load     = 1'b1;
                  rsp_in.angle = req_data.manual_angle;
               end
            end
            OP_TICK: begin
               if (scan_en_ff) begin
                  case (phase_ff)
                     PH_MOVE: begin
                        rsp_load = 1'b1;
                        phase_in = PH_SERVO;
                     end
                     PH_SERVO: begin
                        if (!req_data.servo_busy) begin
                           rsp_load    = 1'b1;
                           rsp_in.kind = KIND_PING;
                           phase_in    = PH_ECHO;
                        end
                     end
                     PH_ECHO: begin
                        if (req_data.echo_ready) begin
                           rsp_load        = 1'b1;
                           rsp_in.kind     = KIND_REPORT;
                           rsp_in.distance = req_data.echo_distance;
                           idx_in          = adv_idx;
                           down_in         = adv_down;
                           phase_in        = PH_MOVE;
                        end
                     end
                     default: begin
                        phase_in = PH_MOVE;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= LOW_ANGLE_RST;
         high_ff      <= HIGH_ANGLE_RST;
         scan_en_ff   <= 1'b0;
         phase_ff     <= PH_MOVE;
         idx_ff       <= IDX_ZERO;
         down_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         scan_en_ff   <= scan_en_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         down_ff      <= down_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SSS_ASSERT(a_rebuild_starts, clock, reset,
      (req_fire && req_data.op == OP_REBUILD) |=> build_busy,
      "rebuild beat did not start the table builder")
   `SSS_ASSERT(a_quiet_build, clock, reset, build_busy |-> !rsp_load,
      "result produced during a table rebuild")
   `SSS_ASSERT(a_report_moves, clock, reset,
      (rsp_load && rsp_in.kind == KIND_REPORT) |=> (phase_ff == PH_MOVE),
      "report not followed by move phase")
   `SSS_ASSERT(a_phase_hold, clock, reset,
      !(req_fire && req_data.op == OP_TICK) |=> $stable(phase_ff),
      "phase changed without a tick")
   `SSS_ASSERT(a_index_range, clock, reset, !idx_ff[IDX_W-1] && (idx_ff < IDX_MAX),
      "table index outside storage")
   `SSS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid,
      "result valid right after reset")

endmodule

`default_nettype wire

/* bench/servo_sonar_scan_sequencer_tb.sv */
`timescale 1ns / 1ps

module servo_sonar_scan_sequencer_tb;
   import sss_pkg::*;

   localparam int CLK_HALF      = 2;
   localparam int RESET_CYCLES  = 8;
   // a rebuild keeps the block busy with no result while the table is built
   localparam int SETTLE_CYCLES = 2 * MAX_STOPS_DEF + 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      SEQ_MOVE       = 2'd0,
      SEQ_WAIT_SERVO = 2'd1,
      SEQ_WAIT_ECHO  = 2'd2
   } seq_phase_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ANGLE_W-1:0]   csr_data = '0;

   // sweep model state
   logic [ANGLE_W-1:0] stop_table [MAX_STOPS_DEF] = '{default: '0};
   int                 stop_total = 0;
   int                 stop_pos = 0;
   bit                 sweeping_down = 1'b0;
   seq_phase_type      seq_phase = SEQ_MOVE;
   logic [ANGLE_W-1:0] cfg_low = LOW_ANGLE_RST;
   logic [ANGLE_W-1:0] cfg_high = HIGH_ANGLE_RST;
   bit                 cfg_scan = 1'b0;

   rsp_type awaited_outputs [$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_gen = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int beats_sent = 0;
   int results_seen = 0;
   int rebuilds_done = 0;

   servo_sonar_scan_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_outputs.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stall, plus a long hold-off whenever hold_gen moves
   always @(negedge clock) begin
      if (hold_gen != hold_seen) begin
         hold_seen = hold_gen;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic flag_error(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (awaited_outputs.size() == 0) begin
            flag_error($sformatf("unexpected result kind %0d angle %0d distance %0d",
                                 rsp_data.kind, rsp_data.angle, rsp_data.distance));
         end else begin
            want = awaited_outputs.pop_front();
            if (rsp_data.kind !== want.kind)
               flag_error($sformatf("kind %0d, expected %0d", rsp_data.kind, want.kind));
            if (rsp_data.angle !== want.angle)
               flag_error($sformatf("angle %0d, expected %0d", rsp_data.angle, want.angle));
            if (rsp_data.distance !== want.distance)
               flag_error($sformatf("distance %0d, expected %0d", rsp_data.distance,
                                    want.distance));
         end
      end
   end

   function automatic logic [ANGLE_W-1:0] stop_angle_at(int pos);
      if (pos < 0 || pos >= MAX_STOPS_DEF)
         return '0;
      return stop_table[pos];
   endfunction

   // advances the sweep model by one accepted beat and queues what it emits
   function automatic void step_sequencer(req_type r);
      rsp_type emitted;
      bit      fire;
      int      lo, hi, swap_tmp, spacing, a, n;
      fire = 1'b0;
      emitted = '0;
      case (r.op)
         OP_REBUILD: begin
            lo = cfg_low;
            hi = cfg_high;
            if (hi < lo) begin
               swap_tmp = lo;
               lo = hi;
               hi = swap_tmp;
            end
            spacing = (hi - lo) / 7;
            if (spacing < MIN_STEP)
               spacing = MIN_STEP;
            n = 0;
            for (a = lo; a < hi && a <= 255; a += spacing) begin
               stop_table[n] = ANGLE_W'(a);
               n++;
               if (n >= MAX_STOPS_DEF - 1)
                  break;
            end
            stop_table[n] = ANGLE_W'(hi);
            n++;
            if (n < 2) begin
               stop_table[0] = ANGLE_W'(lo);
               stop_table[1] = ANGLE_W'(hi);
               n = 2;
            end
            stop_total = n;
            rebuilds_done++;
         end
         OP_MANUAL: begin
            if (!cfg_scan) begin
               emitted.kind = KIND_SERVO;
               emitted.angle = r.manual_angle;
               fire = 1'b1;
            end
         end
         OP_TICK: begin
            if (cfg_scan) begin
               case (seq_phase)
                  SEQ_MOVE: begin
                     emitted.kind = KIND_SERVO;
                     emitted.angle = stop_angle_at(stop_pos);
                     fire = 1'b1;
                     seq_phase = SEQ_WAIT_SERVO;
                  end
                  SEQ_WAIT_SERVO: begin
                     if (!r.servo_busy) begin
                        emitted.kind = KIND_PING;
                        emitted.angle = stop_angle_at(stop_pos);
                        fire = 1'b1;
                        seq_phase = SEQ_WAIT_ECHO;
                     end
                  end
                  SEQ_WAIT_ECHO: begin
                     if (r.echo_ready) begin
                        emitted.kind = KIND_REPORT;
                        emitted.angle = stop_angle_at(stop_pos);
                        emitted.distance = r.echo_distance;
                        fire = 1'b1;
                        // ping-pong walk through the table
                        stop_pos += sweeping_down ? -1 : 1;
                        if (stop_pos >= stop_total) begin
                           stop_pos = stop_total - 2;
                           sweeping_down = 1'b1;
                        end
                        if (stop_pos < 0) begin
                           stop_pos = 1;
                           sweeping_down = 1'b0;
                        end
                        if (stop_pos == 0)
                           sweeping_down = 1'b0;
                        seq_phase = SEQ_MOVE;
                     end
                  end
                  default: seq_phase = SEQ_MOVE;
               endcase
            end
         end
         default: ;
      endcase
      if (fire)
         awaited_outputs.push_back(emitted);
   endfunction

   function automatic req_type make_beat(op_type op, bit busy, bit ready,
                                         logic [DIST_W-1:0] echo_mm,
                                         logic [ANGLE_W-1:0] ang);
      req_type r;
      r.op = op;
      r.servo_busy = busy;
      r.echo_ready = ready;
      r.echo_distance = echo_mm;
      r.manual_angle = ang;
      return r;
   endfunction

   task automatic send_beat(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      step_sequencer(r);
      beats_sent++;
   endtask

   // lower valid, wait out every expected result, then let a rebuild finish
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [ANGLE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LOW_ANGLE:   cfg_low = value;
         CSR_HIGH_ANGLE:  cfg_high = value;
         CSR_SCAN_ENABLE: cfg_scan = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // scan off: ticks do nothing, manual beats command the servo
   task automatic test_disabled_ops();
      csr_write(CSR_UNUSED, 8'hFF);
      send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'hFFFF, 8'd0));
      send_beat(make_beat(OP_MANUAL, 1'b1, 1'b1, 16'h0000, 8'd0));
      send_beat(make_beat(OP_MANUAL, 1'b0, 1'b0, 16'hFFFF, 8'd180));
      send_beat(make_beat(OP_MANUAL, 1'b0, 1'b0, 16'h5A5A, 8'd255));
      send_beat(make_beat(op_type'(OP_RESERVED), 1'b1, 1'b1, 16'hFFFF, 8'hFF));
      drain_results();
   endtask

   // ticks before any rebuild walk an empty table and settle at index one
   task automatic test_empty_table_scan();
      csr_write(CSR_SCAN_ENABLE, 8'd1);
      send_beat(make_beat(OP_MANUAL, 1'b0, 1'b0, 16'd0, 8'd77));
      send_beat(make_beat(OP_TICK, 1'b1, 1'b0, 16'd0, 8'd0));
      send_beat(make_beat(OP_TICK, 1'b1, 1'b0, 16'd0, 8'd0));
      send_beat(make_beat(OP_TICK, 1'b0, 1'b0, 16'd0, 8'd0));
      send_beat(make_beat(OP_TICK, 1'b0, 1'b0, 16'hFFFF, 8'd0));
      send_beat(make_beat(OP_TICK, 1'b1, 1'b1, 16'hFFFF, 8'd0));
      send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'd0, 8'd0));
      send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'd0, 8'd0));
      send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'd0, 8'd0));
      drain_results();
   endtask

   // equal ends, swapped ends, and the full 8-bit span
   task automatic test_table_extremes();
      logic [ANGLE_W-1:0] ends [3][2];
      ends = '{'{8'd90, 8'd90}, '{8'd180, 8'd0}, '{8'd0, 8'd255}};
      for (int k = 0; k < 3; k++) begin
         csr_write(CSR_LOW_ANGLE, ends[k][0]);
         csr_write(CSR_HIGH_ANGLE, ends[k][1]);
         send_beat(make_beat(OP_REBUILD, 1'b0, 1'b0, 16'd0, 8'd0));
         send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'($urandom), 8'd0));
         send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'($urandom), 8'd0));
         send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'($urandom), 8'd0));
         drain_results();
      end
   endtask

   // long receiver hold while ticks keep coming, then wait for everything
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      csr_write(CSR_LOW_ANGLE, 8'd10);
      csr_write(CSR_HIGH_ANGLE, 8'd170);
      send_beat(make_beat(OP_REBUILD, 1'b0, 1'b0, 16'd0, 8'd0));
      hold_gen++;
      for (int k = 0; k < 30; k++)
         send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 16'($urandom), 8'($urandom)));
      drain_results();
   endtask

   task automatic test_random_traffic(int idle_send, int idle_recv, int segments);
      req_type            r;
      int                 pick;
      logic [ANGLE_W-1:0] lo, hi;
      send_idle_pct = idle_send;
      stall_pct = idle_recv;
      for (int seg = 0; seg < segments; seg++) begin
         drain_results();
         case ($urandom_range(5))
            0: begin
               lo = 8'($urandom_range(180));
               hi = lo;
            end
            1: begin
               lo = 8'd0;
               hi = 8'd180;
            end
            2: begin
               lo = 8'd180;
               hi = 8'($urandom_range(180));
            end
            default: begin
               lo = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(180));
               hi = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(180));
            end
         endcase
         csr_write(CSR_LOW_ANGLE, lo);
         csr_write(CSR_HIGH_ANGLE, hi);
         csr_write(CSR_SCAN_ENABLE, {7'($urandom_range(127)), 1'($urandom_range(99) < 85)});
         send_beat(make_beat(OP_REBUILD, 1'($urandom), 1'($urandom), 16'($urandom),
                             8'($urandom)));
         for (int k = 0; k < 54; k++) begin
            // flipping scan mid-sequence must keep phase and index
            if (k == 27 && $urandom_range(99) < 40) begin
               drain_results();
               csr_write(CSR_SCAN_ENABLE, {7'($urandom_range(127)), ~cfg_scan});
            end
            r = make_beat(OP_TICK, 1'($urandom_range(99) < 35), 1'($urandom_range(99) < 60),
                          16'($urandom), 8'($urandom));
            pick = $urandom_range(99);
            if (pick >= 96)
               r.op = op_type'(OP_RESERVED);
            else if (pick >= 93)
               r.op = OP_REBUILD;
            else if (pick >= 82) begin
               r.op = OP_MANUAL;
               r.manual_angle = ($urandom_range(99) < 80) ? 8'($urandom_range(180))
                                                          : 8'($urandom_range(255));
            end
            send_beat(r);
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_ops();
      test_empty_table_scan();
      test_table_extremes();
      test_output_backpressure();
      test_random_traffic(0, 0, 6);
      test_random_traffic(53, 0, 6);
      test_random_traffic(0, 53, 6);
      test_random_traffic(18, 18, 6);

      drain_results();
      send_idle_pct = 0;
      stall_pct = 0;
      $display("covered %0d request beats and %0d table rebuilds across four idle mixes,",
               beats_sent, rebuilds_done);
      $display("with %0d results checked and %0d mismatches", results_seen, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/sss_pkg.sv
rtl/core/sss_table_build.sv
rtl/core/servo_sonar_scan_sequencer.sv
bench/servo_sonar_scan_sequencer_tb.sv
